// ===== design/srt_pkg.sv =====
// Shared types, constants and helpers for the score rank transplant block.
// Used by srt_ctrl, srt_dp and score_rank_transplant; depends on nothing.
package srt_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = IDX_W + 1;
  localparam int VAL_W   = 32;
  localparam int MODE_W  = 3;
  localparam int TIE_W   = 7;
  localparam int CFG_W   = 7;

  localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BASE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BRK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ARK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TOPK = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONFIN = 2'd1;
  localparam logic [1:0] ST_BADK   = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_TOPK = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_START, OP_ERR, OP_OFF,
    OP_RK_RDI, OP_RK_CAPI, OP_RK_J, OP_RK_W, OP_RK_WR,
    OP_RM_RDO, OP_RM_RDR, OP_RM_WR,
    OP_O_RDR, OP_O_RDORD, OP_O_RDV, OP_O_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic fire;
    logic idx_clr;
  } cmd_t;

  typedef struct packed {
    logic row_err;
    logic row_nf;
    logic mode_off;
    logic mode_pass;
    logic mode_topk;
    logic k_zero;
    logic i_last;
    logic j_last;
    logic out_free;
  } sts_t;

  // Maps a finite float32 to an unsigned key with the same order; both zeros map alike.
  function automatic logic [VAL_W-1:0] sort_key(input logic [VAL_W-1:0] bits);
    logic [VAL_W-1:0] k;
    if (bits[VAL_W-2:0] == '0) begin
      k = {1'b1, {(VAL_W-1){1'b0}}};
    end else if (bits[VAL_W-1]) begin
      k = ~bits;
    end else begin
      k = bits | {1'b1, {(VAL_W-1){1'b0}}};
    end
    return k;
  endfunction

  function automatic logic finite_bits(input logic [VAL_W-1:0] bits);
    return bits[30:23] != 8'hFF;
  endfunction

endpackage

// ===== design/score_rank_transplant.sv =====
// Score rank transplant: loads float32 score pairs per row, ranks both vectors in
// the ranking modes and emits one result per key, or one status word for a row in
// error. Throughput: one loaded key per cycle. After the last key and a start state,
// ranking modes run the compare sweep, top-k adds the remap, then each result is read
// and emitted when the output is free. Pass modes, off mode and errors skip the sweep.
// Reset (synchronous, rst_n low): empty row, mode 0, top count 1, no result pending.
module score_rank_transplant (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [srt_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [srt_pkg::VAL_W-1:0]   in_baseline_bits,
  input  logic [srt_pkg::VAL_W-1:0]   in_alternate_bits,
  input  logic                        in_last_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [srt_pkg::VAL_W-1:0]   out_value_bits,
  output logic [srt_pkg::IDX_W-1:0]   out_key_index,
  output logic                        out_has_value,
  output logic [1:0]                  out_status,
  output logic [srt_pkg::TIE_W-1:0]   out_tie_count,
  output logic                        out_row_end
);

  logic [srt_pkg::MODE_W-1:0] mode_r;
  logic [srt_pkg::CFG_W-1:0]  top_r;
  srt_pkg::cmd_t              cmd;
  srt_pkg::sts_t              sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= srt_pkg::MODE_OFF;
      top_r  <= srt_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == srt_pkg::REG_MODE) mode_r <= cfg_data[srt_pkg::MODE_W-1:0];
      else top_r <= cfg_data;
    end
  end

  srt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .sts          (sts),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  srt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .mode              (mode_r),
    .top_count         (top_r),
    .in_baseline_bits  (in_baseline_bits),
    .in_alternate_bits (in_alternate_bits),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_bits    (out_value_bits),
    .out_key_index     (out_key_index),
    .out_has_value     (out_has_value),
    .out_status        (out_status),
    .out_tie_count     (out_tie_count),
    .out_row_end       (out_row_end)
  );

endmodule

// ===== design/srt_ctrl.sv =====
// Controller state machine of the score rank transplant block.
// Depends on srt_pkg; drives srt_dp through cmd_t and reads sts_t.
module srt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_item,
  input  srt_pkg::sts_t sts,
  output logic          in_ready,
  output srt_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_ERR, S_OFF,
    S_RK_RDI, S_RK_CAPI, S_RK_J, S_RK_W, S_RK_WR,
    S_RM_RDO, S_RM_RDR, S_RM_WR,
    S_O_RDR, S_O_RDORD, S_O_RDV, S_O_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = srt_pkg::OP_IDLE;
    cmd.fire    = 1'b0;
    cmd.idx_clr = 1'b0;
    case (state_r)
      S_LOAD: begin
        cmd.op   = srt_pkg::OP_LOAD;
        cmd.fire = in_valid;
        if (in_valid && in_last_item) state_nxt = S_START;
      end
      S_START: begin
        cmd.op      = srt_pkg::OP_START;
        cmd.idx_clr = 1'b1;
        if (sts.row_err) state_nxt = S_ERR;
        else if (sts.mode_off) state_nxt = S_OFF;
        else if (sts.row_nf) state_nxt = S_ERR;
        else if (sts.mode_topk && sts.k_zero) state_nxt = S_ERR;
        else if (sts.mode_pass) state_nxt = S_O_RDR;
        else state_nxt = S_RK_RDI;
      end
      S_ERR: begin
        cmd.op   = srt_pkg::OP_ERR;
        cmd.fire = sts.out_free;
        if (sts.out_free) state_nxt = S_LOAD;
      end
      S_OFF: begin
        cmd.op   = srt_pkg::OP_OFF;
        cmd.fire = sts.out_free;
        if (sts.out_free && sts.i_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_RK_RDI: begin
        cmd.op    = srt_pkg::OP_RK_RDI;
        state_nxt = S_RK_CAPI;
      end
      S_RK_CAPI: begin
        cmd.op    = srt_pkg::OP_RK_CAPI;
        state_nxt = S_RK_J;
      end
      S_RK_J: begin
        cmd.op = srt_pkg::OP_RK_J;
        if (sts.j_last) state_nxt = S_RK_W;
      end
      S_RK_W: begin
        cmd.op    = srt_pkg::OP_RK_W;
        state_nxt = S_RK_WR;
      end
      S_RK_WR: begin
        cmd.op = srt_pkg::OP_RK_WR;
        if (sts.i_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.mode_topk ? S_RM_RDO : S_O_RDR;
        end else begin
          state_nxt = S_RK_RDI;
        end
      end
      S_RM_RDO: begin
        cmd.op    = srt_pkg::OP_RM_RDO;
        state_nxt = S_RM_RDR;
      end
      S_RM_RDR: begin
        cmd.op    = srt_pkg::OP_RM_RDR;
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.op = srt_pkg::OP_RM_WR;
        if (sts.i_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_O_RDR;
        end else begin
          state_nxt = S_RM_RDO;
        end
      end
      S_O_RDR: begin
        cmd.op    = srt_pkg::OP_O_RDR;
        state_nxt = S_O_RDORD;
      end
      S_O_RDORD: begin
        cmd.op    = srt_pkg::OP_O_RDORD;
        state_nxt = S_O_RDV;
      end
      S_O_RDV: begin
        cmd.op    = srt_pkg::OP_O_RDV;
        state_nxt = S_O_EMIT;
      end
      S_O_EMIT: begin
        cmd.op   = srt_pkg::OP_O_EMIT;
        cmd.fire = sts.out_free;
        if (sts.out_free) begin
          if (sts.i_last) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_O_RDR;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign in_ready = (state_r == S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/srt_dp.sv =====
// Datapath of the score rank transplant block: score and rank memories,
// counters, float compare and the output register. Depends on srt_pkg.
module srt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srt_pkg::cmd_t                     cmd,
  output srt_pkg::sts_t                     sts,
  input  logic [srt_pkg::MODE_W-1:0]        mode,
  input  logic [srt_pkg::CFG_W-1:0]         top_count,
  input  logic [srt_pkg::VAL_W-1:0]         in_baseline_bits,
  input  logic [srt_pkg::VAL_W-1:0]         in_alternate_bits,
  input  logic                              in_last_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srt_pkg::VAL_W-1:0]         out_value_bits,
  output logic [srt_pkg::IDX_W-1:0]         out_key_index,
  output logic                              out_has_value,
  output logic [1:0]                        out_status,
  output logic [srt_pkg::TIE_W-1:0]         out_tie_count,
  output logic                              out_row_end
);

  localparam int IW = srt_pkg::IDX_W;
  localparam int LW = srt_pkg::LEN_W;
  localparam int VW = srt_pkg::VAL_W;

  logic [VW-1:0] base_mem  [srt_pkg::MAX_LEN];
  logic [VW-1:0] alt_mem   [srt_pkg::MAX_LEN];
  logic [IW-1:0] bord_mem  [srt_pkg::MAX_LEN];
  logic [IW-1:0] aord_mem  [srt_pkg::MAX_LEN];
  logic [IW-1:0] brank_mem [srt_pkg::MAX_LEN];
  logic [IW-1:0] arank_mem [srt_pkg::MAX_LEN];
  logic [IW-1:0] rem_mem   [srt_pkg::MAX_LEN];

  logic [VW-1:0] base_rd, alt_rd;
  logic [IW-1:0] bord_rd, aord_rd, brank_rd, arank_rd, rem_rd;
  logic [IW-1:0] val_addr, ord_addr, brank_addr;

  logic [LW-1:0] row_len_r, row_len_nxt;
  logic          long_r, long_nxt, nf_r, nf_nxt;
  logic          row_err_r, row_err_nxt, row_nf_r, row_nf_nxt;
  logic [IW-1:0] n_m1_r, n_m1_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, j_d_r;
  logic          pv_r;
  logic [VW-1:0] vb_r, va_r;
  logic [IW-1:0] rb_r, rb_nxt, ra_r, ra_nxt;
  logic          eqb_r, eqb_nxt, eqa_r, eqa_nxt;
  logic [srt_pkg::TIE_W-1:0] ties_r, ties_nxt;
  logic [IW-1:0] tail_r, tail_nxt, key_r;
  logic [IW-1:0] src_r, src_nxt, pos;
  logic [LW-1:0] pos_sum;

  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_value_r, out_value_nxt;
  logic [IW-1:0] out_key_r, out_key_nxt;
  logic          out_has_r, out_has_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [srt_pkg::TIE_W-1:0] out_ties_r, out_ties_nxt;
  logic          out_end_r, out_end_nxt;

  logic          load, store, out_free, use_base, i_last;
  logic [VW-1:0] kvb, kva, kjb, kja;
  logic          gtb, gta, eqb, eqa, before_i;
  logic [1:0]    err_code;
  logic [LW-1:0] n_len;

  assign load     = (cmd.op == srt_pkg::OP_LOAD) && cmd.fire;
  assign store    = load && !row_len_r[LW-1];
  assign out_free = !out_valid_r || out_ready;
  assign i_last   = (i_r == n_m1_r);
  assign use_base = (mode == srt_pkg::MODE_BASE) || (mode == srt_pkg::MODE_ARK);
  assign n_len    = {1'b0, n_m1_r} + LW'(1);

  // Memory read addresses.
  always_comb begin
    val_addr = src_r;
    case (cmd.op)
      srt_pkg::OP_RK_RDI: val_addr = i_r;
      srt_pkg::OP_RK_J:   val_addr = j_r;
      srt_pkg::OP_O_RDV:  val_addr = src_nxt;
      default:            val_addr = src_r;
    endcase
    ord_addr   = (cmd.op == srt_pkg::OP_O_RDORD) ? pos : i_r;
    brank_addr = (cmd.op == srt_pkg::OP_RM_RDR) ? aord_rd : i_r;
  end

  always_ff @(posedge clk) begin
    if (store) begin
      base_mem[row_len_r[IW-1:0]] <= in_baseline_bits;
      alt_mem[row_len_r[IW-1:0]]  <= in_alternate_bits;
    end
    base_rd <= base_mem[val_addr];
    alt_rd  <= alt_mem[val_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == srt_pkg::OP_RK_WR) begin
      bord_mem[rb_r]  <= i_r;
      aord_mem[ra_r]  <= i_r;
      brank_mem[i_r]  <= rb_r;
      arank_mem[i_r]  <= ra_r;
    end
    bord_rd  <= bord_mem[ord_addr];
    aord_rd  <= aord_mem[ord_addr];
    brank_rd <= brank_mem[brank_addr];
    arank_rd <= arank_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == srt_pkg::OP_RM_WR && {1'b0, brank_rd} >= k_r) begin
      rem_mem[key_r] <= tail_r;
    end
    rem_rd <= rem_mem[i_r];
  end

  // Rank compare of the fetched score against the score being ranked.
  always_comb begin
    kvb      = srt_pkg::sort_key(vb_r);
    kva      = srt_pkg::sort_key(va_r);
    kjb      = srt_pkg::sort_key(base_rd);
    kja      = srt_pkg::sort_key(alt_rd);
    gtb      = kjb > kvb;
    gta      = kja > kva;
    before_i = j_d_r < i_r;
    eqb      = (kjb == kvb) && before_i;
    eqa      = (kja == kva) && before_i;
  end

  always_comb begin
    pos_sum = k_r + {1'b0, rem_rd};
    case (mode)
      srt_pkg::MODE_BRK: pos = brank_rd;
      srt_pkg::MODE_ARK: pos = arank_rd;
      default:           pos = ({1'b0, brank_rd} < k_r) ? brank_rd : pos_sum[IW-1:0];
    endcase
    if (mode == srt_pkg::MODE_BASE || mode == srt_pkg::MODE_ALT) src_nxt = i_r;
    else if (mode == srt_pkg::MODE_ARK) src_nxt = bord_rd;
    else src_nxt = aord_rd;
  end

  always_comb begin
    if (row_err_r) err_code = srt_pkg::ST_LONG;
    else if (row_nf_r) err_code = srt_pkg::ST_NONFIN;
    else err_code = srt_pkg::ST_BADK;
  end

  always_comb begin
    row_len_nxt = row_len_r;
    long_nxt    = long_r;
    nf_nxt      = nf_r;
    row_err_nxt = row_err_r;
    row_nf_nxt  = row_nf_r;
    n_m1_nxt    = n_m1_r;
    k_nxt       = k_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    rb_nxt      = rb_r;
    ra_nxt      = ra_r;
    eqb_nxt     = eqb_r;
    eqa_nxt     = eqa_r;
    ties_nxt    = ties_r;
    tail_nxt    = tail_r;
    if (load) begin
      if (in_last_item) begin
        row_len_nxt = '0;
        long_nxt    = 1'b0;
        nf_nxt      = 1'b0;
        row_err_nxt = long_r || row_len_r[LW-1];
        row_nf_nxt  = nf_r || (store && (!srt_pkg::finite_bits(in_baseline_bits) ||
                                         !srt_pkg::finite_bits(in_alternate_bits)));
        n_m1_nxt    = row_len_r[IW-1:0];
      end else if (store) begin
        row_len_nxt = row_len_r + LW'(1);
        nf_nxt      = nf_r || !srt_pkg::finite_bits(in_baseline_bits) ||
                      !srt_pkg::finite_bits(in_alternate_bits);
      end else begin
        long_nxt = 1'b1;
      end
    end
    case (cmd.op)
      srt_pkg::OP_START: begin
        k_nxt    = (top_count < n_len) ? top_count : n_len;
        ties_nxt = '0;
        tail_nxt = '0;
      end
      srt_pkg::OP_RK_CAPI: begin
        j_nxt   = '0;
        rb_nxt  = '0;
        ra_nxt  = '0;
        eqb_nxt = 1'b0;
        eqa_nxt = 1'b0;
      end
      srt_pkg::OP_RK_J: j_nxt = j_r + IW'(1);
      srt_pkg::OP_RK_WR: begin
        ties_nxt = ties_r + srt_pkg::TIE_W'(eqb_r) + srt_pkg::TIE_W'(eqa_r);
        i_nxt    = i_r + IW'(1);
      end
      srt_pkg::OP_RM_WR: begin
        if ({1'b0, brank_rd} >= k_r) tail_nxt = tail_r + IW'(1);
        i_nxt = i_r + IW'(1);
      end
      srt_pkg::OP_OFF, srt_pkg::OP_O_EMIT: begin
        if (cmd.fire) i_nxt = i_r + IW'(1);
      end
      default: i_nxt = i_r;
    endcase
    if (pv_r) begin
      if (gtb || eqb) rb_nxt = rb_r + IW'(1);
      if (gta || eqa) ra_nxt = ra_r + IW'(1);
      if (eqb) eqb_nxt = 1'b1;
      if (eqa) eqa_nxt = 1'b1;
    end
    if (cmd.idx_clr) i_nxt = '0;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_key_nxt    = out_key_r;
    out_has_nxt    = out_has_r;
    out_status_nxt = out_status_r;
    out_ties_nxt   = out_ties_r;
    out_end_nxt    = out_end_r;
    if (cmd.fire) begin
      case (cmd.op)
        srt_pkg::OP_ERR: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_key_nxt    = '0;
          out_has_nxt    = 1'b0;
          out_status_nxt = err_code;
          out_ties_nxt   = '0;
          out_end_nxt    = 1'b1;
        end
        srt_pkg::OP_OFF: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_key_nxt    = i_r;
          out_has_nxt    = 1'b0;
          out_status_nxt = srt_pkg::ST_OK;
          out_ties_nxt   = '0;
          out_end_nxt    = i_last;
        end
        srt_pkg::OP_O_EMIT: begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = use_base ? base_rd : alt_rd;
          out_key_nxt    = i_r;
          out_has_nxt    = 1'b1;
          out_status_nxt = srt_pkg::ST_OK;
          out_ties_nxt   = ties_r;
          out_end_nxt    = i_last;
        end
        default: out_valid_nxt = out_valid_r && !out_ready;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r   <= '0;
      long_r      <= 1'b0;
      nf_r        <= 1'b0;
      row_err_r   <= 1'b0;
      row_nf_r    <= 1'b0;
      i_r         <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_len_r   <= row_len_nxt;
      long_r      <= long_nxt;
      nf_r        <= nf_nxt;
      row_err_r   <= row_err_nxt;
      row_nf_r    <= row_nf_nxt;
      i_r         <= i_nxt;
      pv_r        <= (cmd.op == srt_pkg::OP_RK_J);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_m1_r       <= n_m1_nxt;
    k_r          <= k_nxt;
    j_r          <= j_nxt;
    j_d_r        <= j_r;
    rb_r         <= rb_nxt;
    ra_r         <= ra_nxt;
    eqb_r        <= eqb_nxt;
    eqa_r        <= eqa_nxt;
    ties_r       <= ties_nxt;
    tail_r       <= tail_nxt;
    if (cmd.op == srt_pkg::OP_RK_CAPI) begin
      vb_r <= base_rd;
      va_r <= alt_rd;
    end
    if (cmd.op == srt_pkg::OP_RM_RDR) key_r <= aord_rd;
    if (cmd.op == srt_pkg::OP_O_RDV) src_r <= src_nxt;
    out_value_r  <= out_value_nxt;
    out_key_r    <= out_key_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
    out_ties_r   <= out_ties_nxt;
    out_end_r    <= out_end_nxt;
  end

  always_comb begin
    sts.row_err   = row_err_r;
    sts.row_nf    = row_nf_r;
    sts.mode_off  = (mode == srt_pkg::MODE_OFF) || (mode > srt_pkg::MODE_TOPK);
    sts.mode_pass = (mode == srt_pkg::MODE_BASE) || (mode == srt_pkg::MODE_ALT);
    sts.mode_topk = (mode == srt_pkg::MODE_TOPK);
    sts.k_zero    = (top_count == '0);
    sts.i_last    = i_last;
    sts.j_last    = (j_r == n_m1_r);
    sts.out_free  = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_value_bits = out_value_r;
  assign out_key_index  = out_key_r;
  assign out_has_value  = out_has_r;
  assign out_status     = out_status_r;
  assign out_tie_count  = out_ties_r;
  assign out_row_end    = out_end_r;

  // A rank never reaches past the last key of the row.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == srt_pkg::OP_RK_WR |-> (rb_r <= n_m1_r) && (ra_r <= n_m1_r))
    else $error("rank beyond row length");

  // A new result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_value_r) && $stable(out_key_r))
    else $error("pending result overwritten");

  // Ties are counted in ranking modes only, and never exceed two per key.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == srt_pkg::OP_RK_WR |-> ties_r <= {n_m1_r, 1'b0})
    else $error("tie count out of range");

endmodule

// ===== test/tb_score_rank_transplant.sv =====
// Self-checking testbench for score_rank_transplant: directed rows, then random rows
// under several register settings and handshake idling patterns. Depends on srt_pkg.
module tb_score_rank_transplant;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] base;
    logic [31:0] alt;
    logic        last;
  } key_word_t;

  typedef struct {
    logic [31:0]               value;
    logic [srt_pkg::IDX_W-1:0] key;
    logic                      has;
    logic [1:0]                status;
    logic [srt_pkg::TIE_W-1:0] ties;
    logic                      row_end;
  } score_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [srt_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_baseline_bits = '0;
  logic [31:0] in_alternate_bits = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_value_bits;
  logic [srt_pkg::IDX_W-1:0] out_key_index;
  logic out_has_value;
  logic [1:0] out_status;
  logic [srt_pkg::TIE_W-1:0] out_tie_count;
  logic out_row_end;

  key_word_t   pending_keys[$];
  score_word_t expected_scores[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_req = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  // Predictor copy of the block state and registers.
  logic [31:0] row_base[srt_pkg::MAX_LEN];
  logic [31:0] row_alt[srt_pkg::MAX_LEN];
  int          row_len = 0;
  bit          row_overflow = 0;
  logic [2:0]  cur_mode = srt_pkg::MODE_OFF;
  logic [6:0]  cur_topk = 7'd1;

  score_rank_transplant dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit score_gt(logic [31:0] a, logic [31:0] b);
    logic [30:0] ma, mb;
    ma = a[30:0];
    mb = b[30:0];
    if (ma == 0 && mb == 0) return 0;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return ma > mb;
    return ma < mb;
  endfunction

  function automatic bit score_eq(logic [31:0] a, logic [31:0] b);
    return a[30:0] == b[30:0] && (a[31] == b[31] || a[30:0] == 0);
  endfunction

  // Ranks a vector descending with lower index first; returns the number of adjacent equal pairs.
  function automatic int rank_scores(input logic [31:0] v[srt_pkg::MAX_LEN], input int n,
                                     output int order[srt_pkg::MAX_LEN]);
    int r, ties;
    ties = 0;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < n; j++)
        if (score_gt(v[j], v[i]) || (score_eq(v[j], v[i]) && j < i)) r++;
      order[r] = i;
    end
    for (int i = 1; i < n; i++)
      if (score_eq(v[order[i]], v[order[i-1]])) ties++;
    return ties;
  endfunction

  function automatic void push_score(logic [31:0] v, int key, bit has, logic [1:0] st,
                                     int ties, bit row_end);
    score_word_t w;
    w.value = v;
    w.key = key[srt_pkg::IDX_W-1:0];
    w.has = has;
    w.status = st;
    w.ties = ties[srt_pkg::TIE_W-1:0];
    w.row_end = row_end;
    expected_scores.push_back(w);
  endfunction

  function automatic void transplant_row();
    int n, k, ties, tail;
    int bord[srt_pkg::MAX_LEN];
    int aord[srt_pkg::MAX_LEN];
    int rest[srt_pkg::MAX_LEN];
    bit promoted[srt_pkg::MAX_LEN];
    logic [31:0] res[srt_pkg::MAX_LEN];
    bit nonfinite;
    n = row_len;
    ties = 0;
    nonfinite = 0;
    if (row_overflow) begin
      push_score('0, 0, 0, srt_pkg::ST_LONG, 0, 1);
      return;
    end
    if (cur_mode == srt_pkg::MODE_OFF || cur_mode > srt_pkg::MODE_TOPK) begin
      for (int i = 0; i < n; i++) push_score('0, i, 0, srt_pkg::ST_OK, 0, i == n - 1);
      return;
    end
    for (int i = 0; i < n; i++)
      if (row_base[i][30:23] == 8'hFF || row_alt[i][30:23] == 8'hFF) nonfinite = 1;
    if (nonfinite) begin
      push_score('0, 0, 0, srt_pkg::ST_NONFIN, 0, 1);
      return;
    end
    if (cur_mode == srt_pkg::MODE_TOPK && cur_topk == 0) begin
      push_score('0, 0, 0, srt_pkg::ST_BADK, 0, 1);
      return;
    end
    if (cur_mode == srt_pkg::MODE_BASE) res = row_base;
    else if (cur_mode == srt_pkg::MODE_ALT) res = row_alt;
    else begin
      ties = rank_scores(row_base, n, bord) + rank_scores(row_alt, n, aord);
      if (cur_mode == srt_pkg::MODE_BRK) begin
        for (int i = 0; i < n; i++) res[bord[i]] = row_alt[aord[i]];
      end else if (cur_mode == srt_pkg::MODE_ARK) begin
        for (int i = 0; i < n; i++) res[aord[i]] = row_base[bord[i]];
      end else begin
        k = cur_topk < n ? cur_topk : n;
        for (int i = 0; i < n; i++) promoted[i] = 0;
        for (int i = 0; i < k; i++) promoted[bord[i]] = 1;
        tail = 0;
        for (int i = 0; i < n; i++)
          if (!promoted[aord[i]]) begin
            rest[tail] = aord[i];
            tail++;
          end
        for (int i = 0; i < k; i++) res[bord[i]] = row_alt[aord[i]];
        for (int i = 0; i < tail && k + i < n; i++) res[rest[i]] = row_alt[aord[k + i]];
      end
    end
    for (int i = 0; i < n; i++) push_score(res[i], i, 1, srt_pkg::ST_OK, ties, i == n - 1);
  endfunction

  function automatic void take_key(logic [31:0] b, logic [31:0] a, logic last);
    if (row_len < srt_pkg::MAX_LEN) begin
      row_base[row_len] = b;
      row_alt[row_len] = a;
      row_len++;
    end else begin
      row_overflow = 1;
    end
    if (last) begin
      transplant_row();
      row_len = 0;
      row_overflow = 0;
    end
  endfunction

  // Driver: the word on the bus is retired at the edge where it is accepted.
  always @(posedge clk) begin
    key_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) take_key(in_baseline_bits, in_alternate_bits, in_last_item);
      if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_keys.pop_front();
        in_valid <= 1'b1;
        in_baseline_bits <= w.base;
        in_alternate_bits <= w.alt;
        in_last_item <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    score_word_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result word, key %0d", out_key_index);
          fail_count++;
        end else begin
          e = expected_scores.pop_front();
          if (out_value_bits !== e.value) begin
            $error("value_bits expected %h actual %h", e.value, out_value_bits);
            fail_count++;
          end
          if (out_key_index !== e.key) begin
            $error("key_index expected %0d actual %0d", e.key, out_key_index);
            fail_count++;
          end
          if (out_has_value !== e.has) begin
            $error("has_value expected %0d actual %0d", e.has, out_has_value);
            fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            fail_count++;
          end
          if (out_tie_count !== e.ties) begin
            $error("tie_count expected %0d actual %0d", e.ties, out_tie_count);
            fail_count++;
          end
          if (out_row_end !== e.row_end) begin
            $error("row_end expected %0d actual %0d", e.row_end, out_row_end);
            fail_count++;
          end
        end
      end
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 30000) begin
      $display("score_rank_transplant verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] finite_score();
    logic [31:0] r;
    case ($urandom_range(9))
      0: r = {$urandom_range(1), 31'd0};
      1, 2: begin
        case ($urandom_range(3))
          0: r = 32'h3F800000;
          1: r = 32'hBF800000;
          2: r = 32'h40000000;
          default: r = 32'h80000000;
        endcase
      end
      default: begin
        r = $urandom;
        if (r[30:23] == 8'hFF) r[30] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] nonfinite_score();
    logic [31:0] r;
    r = $urandom;
    r[30:23] = 8'hFF;
    if ($urandom_range(1)) r[22:0] = '0;
    return r;
  endfunction

  function automatic void queue_key(logic [31:0] b, logic [31:0] a, logic last);
    key_word_t w;
    w.base = b;
    w.alt = a;
    w.last = last;
    pending_keys.push_back(w);
  endfunction

  function automatic void queue_random_row(int len);
    logic [31:0] b, a;
    for (int i = 0; i < len; i++) begin
      b = finite_score();
      a = finite_score();
      if ($urandom_range(79) == 0) b = nonfinite_score();
      if ($urandom_range(79) == 0) a = nonfinite_score();
      queue_key(b, a, i == len - 1);
    end
  endfunction

  task automatic settle();
    while (pending_keys.size() > 0 || expected_scores.size() > 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [srt_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srt_pkg::REG_MODE) cur_mode = v[2:0];
    else cur_topk = v;
  endtask

  task automatic queue_directed_row();
    queue_key(32'h00000000, 32'h80000000, 1'b0);
    queue_key(32'h80000000, 32'h00000000, 1'b0);
    queue_key(32'h7F7FFFFF, 32'h00000001, 1'b0);
    queue_key(32'hFF7FFFFF, 32'h80000001, 1'b1);
  endtask

  initial begin
    logic [2:0] modes[12] = '{srt_pkg::MODE_OFF, srt_pkg::MODE_BASE, srt_pkg::MODE_ALT,
                              srt_pkg::MODE_BRK, srt_pkg::MODE_ARK, srt_pkg::MODE_TOPK,
                              srt_pkg::MODE_TOPK, srt_pkg::MODE_TOPK, srt_pkg::MODE_BRK,
                              srt_pkg::MODE_TOPK, srt_pkg::MODE_ARK, srt_pkg::MODE_TOPK};
    int topks[12] = '{1, 5, 5, 2, 2, 1, 64, 3, 0, 0, 9, 2};
    int sends[4] = '{0, 84, 0, 9};
    int recvs[4] = '{0, 0, 84, 9};
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: an off-mode row at reset settings, then extremes in every mode.
    queue_directed_row();
    settle();
    for (int m = srt_pkg::MODE_BASE; m <= srt_pkg::MODE_TOPK; m++) begin
      write_reg(srt_pkg::REG_MODE, m[srt_pkg::CFG_W-1:0]);
      write_reg(srt_pkg::REG_TOPK, 7'd2);
      queue_directed_row();
      settle();
    end
    queue_key(32'h3F800000, 32'hFFFFFFFF, 1'b1);
    queue_key(32'h7F800000, 32'h3F800000, 1'b1);
    queue_key(32'h3F800000, 32'h40000000, 1'b1);
    settle();
    write_reg(srt_pkg::REG_TOPK, 7'd0);
    queue_key(32'h3F800000, 32'h40000000, 1'b1);
    settle();
    // Overlong row: keys past the store size are dropped.
    queue_random_row(srt_pkg::MAX_LEN + 2);
    settle();

    for (int p = 0; p < 12; p++) begin
      write_reg(srt_pkg::REG_MODE, modes[p]);
      write_reg(srt_pkg::REG_TOPK, topks[p][srt_pkg::CFG_W-1:0]);
      send_idle_pct <= sends[p % 4];
      recv_idle_pct <= recvs[p % 4];
      n = 0;
      while (n < 40) begin
        if ($urandom_range(24) == 0) begin
          queue_random_row(srt_pkg::MAX_LEN);
          n += srt_pkg::MAX_LEN;
        end else begin
          queue_random_row($urandom_range(1, 8));
          n += 8;
        end
      end
      if (p == 4) begin
        @(posedge clk);
        stall_req <= stall_req + 1;
      end
      settle();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && expected_scores.size() == 0)
      $display("score_rank_transplant verification clean");
    else
      $display("score_rank_transplant verification failed");
    $finish;
  end
endmodule
